// File: hw/rtl/abe_pkg.sv
package abe_pkg;

    localparam int PL_BYTES = 20;
    localparam int PL_W     = PL_BYTES * 8;
    // signed byte sum over at most PL_BYTES lanes: -2560..2540
    localparam int SUM_W    = 13;
    localparam int NACK_LEN = 17;

    localparam logic [3:0]  NONE_NUM   = 4'hB;
    localparam logic [31:0] NONE_NUM32 = 32'hFFFF_FFFB;

    typedef enum logic [1:0] {
        CMD_MSG     = 2'd0,
        CMD_PKT     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PT_DATA     = 2'd0,
        PT_ACK      = 2'd1,
        PT_DATA_ACK = 2'd2,
        PT_IGNORE   = 2'd3
    } pkt_type_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TX      = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2,
        TMR_RSVD  = 2'd3
    } timer_t;

    // "dummy nack packet"
    localparam logic [7:0] NACK_TEXT [NACK_LEN] = '{
        8'h64, 8'h75, 8'h6d, 8'h6d, 8'h79, 8'h20, 8'h6e, 8'h61, 8'h63,
        8'h6b, 8'h20, 8'h70, 8'h61, 8'h63, 8'h6b, 8'h65, 8'h74
    };

    // item held between the byte-lane stage and the protocol stage
    typedef struct packed {
        logic [1:0]          cmd;
        logic [1:0]          ptype;
        logic signed [23:0]  seq;
        logic signed [23:0]  ack;
        logic [31:0]         check;
        logic [PL_W-1:0]     payload;
        logic signed [SUM_W-1:0] sum;
    } stage_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      ptype;
        logic [3:0]      seq;
        logic [3:0]      ack;
        logic [31:0]     check;
        logic [PL_W-1:0] payload;
        logic [1:0]      timer;
    } result_t;

    function automatic logic [PL_W-1:0] nack_payload(input int nbytes);
        logic [PL_W-1:0] p;
        p = '0;
        for (int i = 0; i < NACK_LEN; i++) begin
            if (i < nbytes) begin
                p[i*8 +: 8] = NACK_TEXT[i];
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] nack_sum(input int nbytes);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < NACK_LEN; i++) begin
            if (i < nbytes) begin
                s = s + {24'd0, NACK_TEXT[i]};
            end
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/abe_lane.sv
module abe_lane
    import abe_pkg::*;
(
    input  logic [7:0]        byte_in,
    input  logic              alive_in,
    output logic              alive_out,
    output logic [7:0]        byte_out,
    output logic signed [8:0] value_out
);

    // a lane stays live only while every byte before it and itself is nonzero
    assign alive_out = alive_in & (|byte_in);
    assign byte_out  = alive_out ? byte_in : 8'd0;
    assign value_out = alive_out ? $signed({byte_in[7], byte_in}) : 9'sd0;

endmodule

// File: hw/rtl/abe_merge.sv
module abe_merge
    import abe_pkg::*;
#(
    parameter int NUM_LANES = 20
) (
    input  logic [PL_W-1:0]         payload_in,
    output logic [PL_W-1:0]         payload_out,
    output logic signed [SUM_W-1:0] sum_out
);

    logic                alive [NUM_LANES+1];
    logic [7:0]          lane_byte [NUM_LANES];
    logic signed [8:0]   lane_val [NUM_LANES];

    // five-level adder tree; leaves past the last lane stay zero
    logic signed [SUM_W-1:0] lvl0 [32];
    logic signed [SUM_W-1:0] lvl1 [16];
    logic signed [SUM_W-1:0] lvl2 [8];
    logic signed [SUM_W-1:0] lvl3 [4];
    logic signed [SUM_W-1:0] lvl4 [2];

    assign alive[0] = 1'b1;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        abe_lane u_lane (
            .byte_in   (payload_in[i*8 +: 8]),
            .alive_in  (alive[i]),
            .alive_out (alive[i+1]),
            .byte_out  (lane_byte[i]),
            .value_out (lane_val[i])
        );
    end

    always_comb begin
        payload_out = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            payload_out[i*8 +: 8] = lane_byte[i];
        end
        for (int i = 0; i < 32; i++) begin
            lvl0[i] = '0;
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            lvl0[i] = SUM_W'(lane_val[i]);
        end
        for (int i = 0; i < 16; i++) begin
            lvl1[i] = lvl0[2*i] + lvl0[2*i+1];
        end
        for (int i = 0; i < 8; i++) begin
            lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
        end
        for (int i = 0; i < 4; i++) begin
            lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            lvl4[i] = lvl3[2*i] + lvl3[2*i+1];
        end
        sum_out = lvl4[0] + lvl4[1];
    end

endmodule

// File: hw/rtl/abe_proto.sv
module abe_proto
    import abe_pkg::*;
#(
    parameter int NUM_LANES = 20
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    st_valid,
    input  stage_t  st,
    output logic    out_valid,
    output result_t res
);

    localparam logic [PL_W-1:0] NACK_PAYLOAD = nack_payload(NUM_LANES);
    localparam logic [31:0]     NACK_SUM     = nack_sum(NUM_LANES);

    logic send_bit_reg, send_bit_next;
    logic awaiting_reg, awaiting_next;
    logic expect_reg, expect_next;
    logic piggy_valid_reg, piggy_valid_next;
    logic piggy_ack_reg, piggy_ack_next;
    logic out_valid_reg;
    result_t res_reg, res_next;

    logic [1:0]      saved_type_reg;
    logic            saved_seq_reg;
    logic [3:0]      saved_ack_reg;
    logic [31:0]     saved_check_reg;
    logic [PL_W-1:0] saved_payload_reg;
    logic            save_en;

    logic [31:0] sum32;
    logic [31:0] rx_check;
    logic [31:0] tx_ack32;
    logic [31:0] tx_check;
    logic [31:0] nack_check;
    logic        check_ok;
    logic        seq_match;
    logic        ack_match;
    logic        step;

    assign step  = st_valid & en;
    assign sum32 = {{(32-SUM_W){st.sum[SUM_W-1]}}, st.sum};

    assign rx_check = {30'd0, st.ptype} + {{8{st.seq[23]}}, st.seq}
                    + {{8{st.ack[23]}}, st.ack} + sum32;
    assign check_ok  = (rx_check == st.check);
    assign seq_match = (st.seq == {23'd0, expect_reg});
    assign ack_match = (st.ack == {23'd0, send_bit_reg});

    assign tx_ack32 = piggy_valid_reg ? {31'd0, piggy_ack_reg} : NONE_NUM32;
    assign tx_check = (piggy_valid_reg ? 32'd2 : 32'd0) + {31'd0, send_bit_reg}
                    + tx_ack32 + sum32;
    assign nack_check = 32'd1 + NONE_NUM32 + {31'd0, ~expect_reg} + NACK_SUM;

    always_comb begin
        send_bit_next    = send_bit_reg;
        awaiting_next    = awaiting_reg;
        expect_next      = expect_reg;
        piggy_valid_next = piggy_valid_reg;
        piggy_ack_next   = piggy_ack_reg;
        save_en          = 1'b0;
        res_next         = '0;
        res_next.kind    = KIND_NONE;
        res_next.timer   = TMR_NONE;

        case (cmd_t'(st.cmd))
            CMD_MSG: begin
                if (awaiting_reg) begin
                    res_next.kind = KIND_DROP;
                end else begin
                    res_next.kind    = KIND_TX;
                    res_next.ptype   = piggy_valid_reg ? PT_DATA_ACK : PT_DATA;
                    res_next.seq     = {3'd0, send_bit_reg};
                    res_next.ack     = tx_ack32[3:0];
                    res_next.check   = tx_check;
                    res_next.payload = st.payload;
                    res_next.timer   = TMR_START;
                    save_en          = 1'b1;
                    awaiting_next    = 1'b1;
                end
            end
            CMD_PKT: begin
                if (!check_ok) begin
                    res_next.kind    = KIND_TX;
                    res_next.ptype   = PT_ACK;
                    res_next.seq     = NONE_NUM;
                    res_next.ack     = {3'd0, ~expect_reg};
                    res_next.check   = nack_check;
                    res_next.payload = NACK_PAYLOAD;
                    piggy_valid_next = 1'b0;
                end else begin
                    if (st.ptype == PT_DATA || st.ptype == PT_DATA_ACK) begin
                        if (!seq_match) begin
                            res_next.kind    = KIND_TX;
                            res_next.ptype   = PT_ACK;
                            res_next.seq     = NONE_NUM;
                            res_next.ack     = {3'd0, ~expect_reg};
                            res_next.check   = nack_check;
                            res_next.payload = NACK_PAYLOAD;
                            piggy_valid_next = 1'b0;
                        end else begin
                            res_next.kind    = KIND_DELIVER;
                            res_next.payload = st.payload;
                            piggy_valid_next = 1'b1;
                            piggy_ack_next   = expect_reg;
                            expect_next      = ~expect_reg;
                        end
                    end
                    // ack half of a combined frame can stop the timer even after a nack
                    if ((st.ptype == PT_ACK || st.ptype == PT_DATA_ACK)
                        && awaiting_reg && ack_match) begin
                        res_next.timer = TMR_STOP;
                        awaiting_next  = 1'b0;
                        send_bit_next  = ~send_bit_reg;
                    end
                end
            end
            CMD_TIMEOUT: begin
                res_next.kind    = KIND_TX;
                res_next.ptype   = saved_type_reg;
                res_next.seq     = {3'd0, saved_seq_reg};
                res_next.ack     = saved_ack_reg;
                res_next.check   = saved_check_reg;
                res_next.payload = saved_payload_reg;
                res_next.timer   = TMR_START;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_bit_reg    <= 1'b0;
            awaiting_reg    <= 1'b0;
            expect_reg      <= 1'b0;
            piggy_valid_reg <= 1'b0;
            piggy_ack_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (en) begin
                out_valid_reg <= st_valid;
            end
            if (step) begin
                send_bit_reg    <= send_bit_next;
                awaiting_reg    <= awaiting_next;
                expect_reg      <= expect_next;
                piggy_valid_reg <= piggy_valid_next;
                piggy_ack_reg   <= piggy_ack_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
        if (step && save_en) begin
            saved_type_reg    <= res_next.ptype;
            saved_seq_reg     <= send_bit_reg;
            saved_ack_reg     <= res_next.ack;
            saved_check_reg   <= res_next.check;
            saved_payload_reg <= res_next.payload;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/alternating_bit_endpoint_core.sv
// channel   direction  handshake          payload
// s_*       in         s_valid / s_ready  command, pkt_type, seq/ack numbers, checksum, payload
// m_*       out        m_valid / m_ready  result kind, frame header, payload, timer command
//
// One item per cycle sustained while m_ready is high; each item is registered in stage 1, then stage 2.
// Stage 1 registers the item after the byte lanes and their adder tree; stage 2 checks
// the checksum, updates the link state and registers the result.
// aresetn (synchronous) clears both stage valids and the link state; the saved frame
// is not reset. With m_ready low the output holds, stage 1 fills, then s_ready drops.
module alternating_bit_endpoint_core
    import abe_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 20
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [1:0]         s_pkt_type,
    input  logic signed [23:0] s_seq_num,
    input  logic signed [23:0] s_ack_num,
    input  logic signed [31:0] s_check_in,
    input  logic [63:0]        s_payload_lo,
    input  logic [63:0]        s_payload_mid,
    input  logic [31:0]        s_payload_hi,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic [1:0]         m_out_type,
    output logic signed [3:0]  m_out_seq,
    output logic signed [3:0]  m_out_ack,
    output logic signed [31:0] m_out_check,
    output logic [63:0]        m_out_payload_lo,
    output logic [63:0]        m_out_payload_mid,
    output logic [31:0]        m_out_payload_hi,
    output logic [1:0]         m_timer_cmd
);

    localparam int NUM_LANES = (PAYLOAD_BYTES < PL_BYTES) ? PAYLOAD_BYTES : PL_BYTES;

    logic                    en;
    logic                    st1_valid_reg;
    stage_t                  st1_reg;
    stage_t                  st1_next;
    logic [PL_W-1:0]         lane_payload;
    logic signed [SUM_W-1:0] lane_sum;
    result_t                 res;

    assign en      = !m_valid || m_ready;
    assign s_ready = en || !st1_valid_reg;

    abe_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .payload_in  ({s_payload_hi, s_payload_mid, s_payload_lo}),
        .payload_out (lane_payload),
        .sum_out     (lane_sum)
    );

    always_comb begin
        st1_next.cmd     = s_command;
        st1_next.ptype   = s_pkt_type;
        st1_next.seq     = s_seq_num;
        st1_next.ack     = s_ack_num;
        st1_next.check   = s_check_in;
        st1_next.payload = lane_payload;
        st1_next.sum     = lane_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            st1_reg <= st1_next;
        end
    end

    abe_proto #(
        .NUM_LANES (NUM_LANES)
    ) u_proto (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .st_valid  (st1_valid_reg),
        .st        (st1_reg),
        .out_valid (m_valid),
        .res       (res)
    );

    assign m_result_kind     = res.kind;
    assign m_out_type        = res.ptype;
    assign m_out_seq         = res.seq;
    assign m_out_ack         = res.ack;
    assign m_out_check       = res.check;
    assign m_out_payload_lo  = res.payload[63:0];
    assign m_out_payload_mid = res.payload[127:64];
    assign m_out_payload_hi  = res.payload[159:128];
    assign m_timer_cmd       = res.timer;

    a_drop_is_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_DROP |->
            m_timer_cmd == TMR_NONE && m_out_payload_lo == 64'd0 && m_out_check == 32'd0)
        else $error("dropped message carries frame or timer data");

    a_deliver_no_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_DELIVER |->
            m_out_type == PT_DATA && m_out_check == 32'd0 && m_timer_cmd != TMR_START)
        else $error("delivered item carries a transmit header");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && m_valid && !m_ready |=> st1_valid_reg && $stable(st1_reg))
        else $error("stage 1 item lost during output stall");

    a_start_only_on_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timer_cmd == TMR_START |-> m_result_kind == KIND_TX)
        else $error("timer start without a transmitted frame");

endmodule
